// ===== hw/rtl/pwmcap_pkg.sv =====
// Shared types and constants for the PWM duty and frequency capture block.
`default_nettype none

package pwmcap_pkg;

    localparam int unsigned NUM_CHANNELS_DEF = 2;
    localparam logic [31:0] TICK_RATE_RESET  = 32'd1000000;
    localparam int unsigned PERCENT_SCALE    = 100;

    // Divider geometry: 32 quotient bits at most, 33-bit divisor/remainder.
    localparam int unsigned DIV_BITS = 32;
    localparam int unsigned REM_W    = 33;
    localparam int unsigned STEP_W   = 6;
    localparam int unsigned DUTY_W   = 7;
    localparam int unsigned PROD_W   = DIV_BITS + DUTY_W;

    localparam logic [STEP_W-1:0] DUTY_STEPS = STEP_W'(DUTY_W);
    localparam logic [STEP_W-1:0] FREQ_STEPS = STEP_W'(DIV_BITS);

    localparam logic [1:0] LVL_FALL = 2'd0;
    localparam logic [1:0] LVL_RISE = 2'd1;

    typedef struct packed {
        logic                start;
        logic [REM_W-1:0]    rem_init;
        logic [DIV_BITS-1:0] bits;
        logic [STEP_W-1:0]   steps;
        logic [REM_W-1:0]    den;
    } t_div_req;

endpackage

`default_nettype wire

// ===== hw/rtl/pwmcap_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module pwmcap_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire pwmcap_pkg::t_div_req         i_req,
    output logic                              o_done,
    output logic [pwmcap_pkg::DIV_BITS-1:0]   o_quo
);
    import pwmcap_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_cnt;
    logic [REM_W-1:0]    r_rem;
    logic [REM_W-1:0]    r_den;
    logic [DIV_BITS-1:0] r_bits;
    logic [DIV_BITS-1:0] r_quo;

    logic [REM_W:0]      trial;
    logic                take;

    // Partial remainder stays below the divisor, so REM_W+1 bits hold the shift.
    assign trial = {r_rem, r_bits[DIV_BITS-1]} - {1'b0, r_den};
    assign take  = !trial[REM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
                r_rem  <= i_req.rem_init;
                r_den  <= i_req.den;
                r_bits <= i_req.bits;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_rem  <= take ? trial[REM_W-1:0] : {r_rem[REM_W-2:0], r_bits[DIV_BITS-1]};
                r_bits <= {r_bits[DIV_BITS-2:0], 1'b0};
                r_quo  <= {r_quo[DIV_BITS-2:0], take};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");

endmodule

`default_nettype wire

// ===== hw/rtl/pwm_duty_frequency_capture.sv =====
// Top level: per-channel PWM edge capture with duty and frequency readout.
`default_nettype none

// Each item is an edge event (channel, level, tick). Rising edges record the
// tick and the low time, falling edges the tick and the high time; levels
// 2 and 3 change nothing. Every item yields one result with the channel's
// duty in percent and tick_rate/period in Hz, zero when nothing has been
// measured. An item passes from acceptance to result through state update,
// the x100 product and the period check, then one shared radix-2 divider
// runs 7 steps for the duty and 32 steps for the frequency. Items with a
// zero period or an unused channel skip the divider. The input is not ready
// while an item is in work; a finished result sits in the output register
// so the next item can be taken while it waits.
module pwm_duty_frequency_capture #(
    parameter int unsigned NUM_CHANNELS = pwmcap_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_channel,
    input  wire logic [1:0]  i_level,
    input  wire logic [31:0] i_tick,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_channel_out,
    output logic [6:0]       o_duty_percent,
    output logic [31:0]      o_frequency_hz
);
    import pwmcap_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_UPDATE, S_MUL, S_CHECK, S_DUTY, S_FREQ, S_OUT
    } t_state;

    t_state              r_state;
    logic [31:0]         r_tick_rate;
    logic                r_ch;
    logic [1:0]          r_level;
    logic [31:0]         r_tick;
    logic                r_ch_ok;
    logic [PROD_W-1:0]   r_prod;
    logic [REM_W-1:0]    r_period;
    logic [DUTY_W-1:0]   r_duty;
    logic [31:0]         r_freq;
    logic                r_out_valid;
    logic                r_out_ch;
    logic [DUTY_W-1:0]   r_out_duty;
    logic [31:0]         r_out_freq;

    logic [31:0] r_rise [NUM_CHANNELS];
    logic [31:0] r_fall [NUM_CHANNELS];
    logic [31:0] r_high [NUM_CHANNELS];
    logic [31:0] r_low  [NUM_CHANNELS];

    logic [31:0] rd_rise, rd_fall, rd_high, rd_low;
    logic        ch_ok;
    t_div_req    div_req;
    logic        div_done;
    logic [DIV_BITS-1:0] div_quo;

    assign ch_ok = (int'(r_ch) < NUM_CHANNELS);

    always_comb begin
        rd_rise = '0;
        rd_fall = '0;
        rd_high = '0;
        rd_low  = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (i == int'(r_ch)) begin
                rd_rise = r_rise[i];
                rd_fall = r_fall[i];
                rd_high = r_high[i];
                rd_low  = r_low[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_rise[i] <= '0;
                r_fall[i] <= '0;
                r_high[i] <= '0;
                r_low[i]  <= '0;
            end
        end else if (r_state == S_UPDATE) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                if (i == int'(r_ch)) begin
                    if (r_level == LVL_RISE) begin
                        r_rise[i] <= r_tick;
                        r_low[i]  <= r_tick - rd_fall;
                    end else if (r_level == LVL_FALL) begin
                        r_high[i] <= r_tick - rd_rise;
                        r_fall[i] <= r_tick;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_rate <= TICK_RATE_RESET;
        end else if (i_cfg_we) begin
            r_tick_rate <= i_cfg_wdata;
        end
    end

    // Both divisions share one divisor: the period.
    always_comb begin
        div_req          = '0;
        div_req.den      = r_period;
        if (r_state == S_CHECK) begin
            div_req.start    = r_ch_ok && (r_period != '0);
            div_req.rem_init = {1'b0, r_prod[PROD_W-1:DUTY_W]};
            div_req.bits     = {r_prod[DUTY_W-1:0], (DIV_BITS-DUTY_W)'(0)};
            div_req.steps    = DUTY_STEPS;
        end else if (r_state == S_DUTY) begin
            div_req.start    = div_done;
            div_req.bits     = r_tick_rate;
            div_req.steps    = FREQ_STEPS;
        end
    end

    pwmcap_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // S_OUT refills the output register itself
            if (r_out_valid && i_out_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_ch    <= i_channel;
                        r_level <= i_level;
                        r_tick  <= i_tick;
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_ch_ok <= ch_ok;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod   <= PROD_W'(rd_high) * PROD_W'(PERCENT_SCALE);
                    r_period <= REM_W'(rd_high) + REM_W'(rd_low);
                    r_state  <= S_CHECK;
                end
                S_CHECK: begin
                    r_duty <= '0;
                    r_freq <= '0;
                    if (div_req.start) begin
                        r_state <= S_DUTY;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_DUTY: begin
                    if (div_done) begin
                        r_duty  <= div_quo[DUTY_W-1:0];
                        r_state <= S_FREQ;
                    end
                end
                S_FREQ: begin
                    if (div_done) begin
                        r_freq  <= div_quo;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_ch    <= r_ch;
                        r_out_duty  <= r_duty;
                        r_out_freq  <= r_freq;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_channel_out  = r_out_ch;
    assign o_duty_percent = r_out_duty;
    assign o_frequency_hz = r_out_freq;

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_duty <= DUTY_W'(PERCENT_SCALE)))
        else $error("duty above full scale");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUTY || r_state == S_FREQ) |-> (r_period != '0))
        else $error("division started with zero period");

    a_accept_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_UPDATE))
        else $error("accepted item did not enter update");

endmodule

`default_nettype wire
